// ----- sv/hed_pkg.sv -----
// Shared types, constants and the CORDIC angle table for the heading/distance core.
`default_nettype none
package hed_pkg;

    localparam int GUARD_BITS = 8;
    localparam int XW = 44;             // CORDIC x/y width
    localparam int ZW = 35;             // CORDIC angle width, Q30 radians
    localparam int DW = 33;             // coordinate difference width
    localparam int HW = 20;             // heading width
    localparam int AW = 21;             // rounded angle width, Q16
    localparam int TW = 19;             // turn angle width
    localparam int UW = 43;             // magnitude width fed to the gain multiply
    localparam int UL = 22;             // low split of the magnitude

    localparam logic signed [ZW-1:0] PI_Q30     = 35'sd3373259426;
    localparam logic [31:0]          INV_GAIN   = 32'd2608131496;
    localparam logic signed [22:0]   PI_Q16     = 23'sd205887;
    localparam logic signed [22:0]   TWO_PI_Q16 = 23'sd411775;
    localparam logic signed [22:0]   TURN_LIMIT = 23'sd205888;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic signed [HW-1:0] hd;
        logic                 zero;
    } hed_vec_t;

    // floor(atan(2^-i) * 2^30)
    function automatic logic [29:0] stage_angle(input logic [4:0] idx);
        logic [29:0] a;
        case (idx)
            5'd0:    a = 30'd843314856;
            5'd1:    a = 30'd497837829;
            5'd2:    a = 30'd263043836;
            5'd3:    a = 30'd133525158;
            5'd4:    a = 30'd67021686;
            5'd5:    a = 30'd33543515;
            5'd6:    a = 30'd16775850;
            5'd7:    a = 30'd8388437;
            5'd8:    a = 30'd4194282;
            5'd9:    a = 30'd2097149;
            5'd10:   a = 30'd1048575;
            5'd11:   a = 30'd524287;
            5'd12:   a = 30'd262143;
            5'd13:   a = 30'd131071;
            5'd14:   a = 30'd65535;
            5'd15:   a = 30'd32767;
            5'd16:   a = 30'd16383;
            5'd17:   a = 30'd8191;
            5'd18:   a = 30'd4095;
            5'd19:   a = 30'd2047;
            5'd20:   a = 30'd1023;
            5'd21:   a = 30'd511;
            5'd22:   a = 30'd255;
            5'd23:   a = 30'd127;
            5'd24:   a = 30'd63;
            5'd25:   a = 30'd31;
            5'd26:   a = 30'd15;
            5'd27:   a = 30'd7;
            5'd28:   a = 30'd3;
            5'd29:   a = 30'd1;
            default: a = 30'd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// ----- sv/hed_prep.sv -----
// Front stages: coordinate differences, then fold into the right half plane.
`default_nettype none
module hed_prep (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [31:0]            from_x,
    input  wire logic signed [31:0]            from_y,
    input  wire logic signed [19:0]            from_heading,
    input  wire logic signed [31:0]            to_x,
    input  wire logic signed [31:0]            to_y,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output hed_pkg::hed_vec_t                  out_data
);
    import hed_pkg::*;

    logic                 a_valid_reg;
    logic                 a_ready;
    logic signed [DW-1:0] dx_reg, dy_reg, dx_next, dy_next;
    logic signed [HW-1:0] hd_reg;
    logic                 b_valid_reg;
    hed_vec_t             b_data_reg, b_data_next;
    logic signed [XW-1:0] xs, ys;

    assign dx_next = $signed({to_x[31], to_x}) - $signed({from_x[31], from_x});
    assign dy_next = $signed({to_y[31], to_y}) - $signed({from_y[31], from_y});

    assign in_ready  = !a_valid_reg || a_ready;
    assign a_ready   = !b_valid_reg || out_ready;
    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (a_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    assign xs = $signed({{(XW-DW-GUARD_BITS){dx_reg[DW-1]}}, dx_reg, {GUARD_BITS{1'b0}}});
    assign ys = $signed({{(XW-DW-GUARD_BITS){dy_reg[DW-1]}}, dy_reg, {GUARD_BITS{1'b0}}});

    // Left half plane: negate the vector and start from +-pi.
    always_comb
    begin
        b_data_next.hd   = hd_reg;
        b_data_next.zero = (dx_reg == '0) && (dy_reg == '0);
        if (dx_reg[DW-1])
        begin
            b_data_next.x = -xs;
            b_data_next.y = -ys;
            b_data_next.z = dy_reg[DW-1] ? -PI_Q30 : PI_Q30;
        end
        else
        begin
            b_data_next.x = xs;
            b_data_next.y = ys;
            b_data_next.z = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            hd_reg <= from_heading;
        end
        if (a_valid_reg && a_ready)
        begin
            b_data_reg <= b_data_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/hed_cordic_stage.sv -----
// One registered CORDIC vectoring iteration.
`default_nettype none
module hed_cordic_stage #(
    parameter int STAGE = 0
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire hed_pkg::hed_vec_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output hed_pkg::hed_vec_t      out_data
);
    import hed_pkg::*;

    localparam logic signed [ZW-1:0] ANGLE =
        $signed({{(ZW-30){1'b0}}, stage_angle(5'(STAGE))});

    logic                 valid_reg;
    hed_vec_t             data_reg, data_next;
    logic signed [XW-1:0] x_in, y_in, xs, ys;

    assign x_in = in_data.x;
    assign y_in = in_data.y;
    assign xs   = x_in >>> STAGE;
    assign ys   = y_in >>> STAGE;

    // Rotate toward the x axis; zero y counts as non-negative.
    always_comb
    begin
        data_next.hd   = in_data.hd;
        data_next.zero = in_data.zero;
        if (y_in[XW-1])
        begin
            data_next.x = x_in - ys;
            data_next.y = y_in + xs;
            data_next.z = in_data.z - ANGLE;
        end
        else
        begin
            data_next.x = x_in + ys;
            data_next.y = y_in - xs;
            data_next.z = in_data.z + ANGLE;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/hed_post.sv -----
// Back stages: gain removal, angle rounding, heading subtraction and wrap.
`default_nettype none
module hed_post (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire hed_pkg::hed_vec_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic signed [18:0]     turn_angle,
    output logic [32:0]            distance,
    output logic                   no_move
);
    import hed_pkg::*;

    // Stage 1: split gain multiply and angle rounding
    logic                 p1_valid_reg, p1_ready;
    logic [UL+31:0]       plo_reg;
    logic [UW-UL+31:0]    phi_reg;
    logic signed [AW-1:0] a_reg, a_next;
    logic signed [HW-1:0] hd1_reg;
    logic                 zero1_reg;
    logic [UW-1:0]        ux;
    logic signed [ZW-1:0] z_round;

    // Stage 2: product sum and heading subtraction
    logic                 p2_valid_reg, p2_ready;
    logic [32:0]          dist2_reg;
    logic [UW+31:0]       prod_sum;
    logic signed [21:0]   d_reg, d_next;
    logic                 zero2_reg;

    // Stage 3: wrap, saturate, output register
    logic                 p3_valid_reg;
    logic signed [TW-1:0] turn_reg, turn_next;
    logic [32:0]          dist_reg;
    logic                 no_move_reg;
    logic signed [22:0]   dw, dc;

    assign ux      = in_data.x[XW-1] ? '0 : in_data.x[UW-1:0];
    assign z_round = in_data.z + $signed(ZW'(8192));
    assign a_next  = AW'(z_round >>> 14);

    assign prod_sum = {phi_reg, {UL{1'b0}}} + (UW+32)'(plo_reg);
    assign d_next   = $signed({a_reg[AW-1], a_reg}) - $signed({{2{hd1_reg[HW-1]}}, hd1_reg});

    always_comb
    begin
        dw = $signed({d_reg[21], d_reg});
        if (dw < -PI_Q16)
        begin
            dc = dw + TWO_PI_Q16;
        end
        else if (dw > PI_Q16)
        begin
            dc = dw - TWO_PI_Q16;
        end
        else
        begin
            dc = dw;
        end
        if (dc > TURN_LIMIT)
        begin
            turn_next = TW'(TURN_LIMIT);
        end
        else if (dc < -TURN_LIMIT)
        begin
            turn_next = TW'(-TURN_LIMIT);
        end
        else
        begin
            turn_next = TW'(dc);
        end
    end

    assign in_ready  = !p1_valid_reg || p1_ready;
    assign p1_ready  = !p2_valid_reg || p2_ready;
    assign p2_ready  = !p3_valid_reg || out_ready;
    assign out_valid = p3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                p1_valid_reg <= in_valid;
            end
            if (p1_ready)
            begin
                p2_valid_reg <= p1_valid_reg;
            end
            if (p2_ready)
            begin
                p3_valid_reg <= p2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            plo_reg   <= (UL+32)'(ux[UL-1:0]) * (UL+32)'(INV_GAIN);
            phi_reg   <= (UW-UL+32)'(ux[UW-1:UL]) * (UW-UL+32)'(INV_GAIN);
            a_reg     <= a_next;
            hd1_reg   <= in_data.hd;
            zero1_reg <= in_data.zero;
        end
        if (p1_valid_reg && p1_ready)
        begin
            dist2_reg <= prod_sum[GUARD_BITS+32+32:GUARD_BITS+32];
            d_reg     <= d_next;
            zero2_reg <= zero1_reg;
        end
        // Target on top of the current position: force both results to zero.
        if (p2_valid_reg && p2_ready)
        begin
            turn_reg    <= zero2_reg ? '0 : turn_next;
            dist_reg    <= zero2_reg ? '0 : dist2_reg;
            no_move_reg <= zero2_reg;
        end
    end

    assign turn_angle = turn_reg;
    assign distance   = dist_reg;
    assign no_move    = no_move_reg;

endmodule
`default_nettype wire

// ----- sv/heading_error_and_distance_core.sv -----
// Top level: heading error and distance to a target point by pipelined CORDIC vectoring.
// Pipeline: 2 front stages, one per CORDIC iteration, 3 back stages for gain multiply,
//   heading subtraction and wrap. Throughput: one item per cycle unless stalled;
//   every stage is its own register with a valid bit.
// Backpressure: a stage holds when the next one is full and stalled, so empty stages fill.
// Reset: rst_n asynchronous, active low, clears all valid bits; data registers not reset.
`default_nettype none
module heading_error_and_distance_core #(
    parameter int CORDIC_STAGES = 24
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // from_x[31:0], from_y[63:32], from_heading[83:64], to_x[115:84], to_y[147:116], zero pad
    input  wire logic [151:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // turn_angle[18:0], distance[51:19], zero pad
    output logic [55:0]       m_axis_tdata,
    // no_move[0]
    output logic [0:0]        m_axis_tuser
);
    import hed_pkg::*;

    logic                 cv_valid [CORDIC_STAGES+1];
    logic                 cv_ready [CORDIC_STAGES+1];
    hed_vec_t             cv_data  [CORDIC_STAGES+1];
    logic signed [18:0]   turn_angle;
    logic [32:0]          distance;
    logic                 no_move;

    hed_prep u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .from_x       ($signed(s_axis_tdata[31:0])),
        .from_y       ($signed(s_axis_tdata[63:32])),
        .from_heading ($signed(s_axis_tdata[83:64])),
        .to_x         ($signed(s_axis_tdata[115:84])),
        .to_y         ($signed(s_axis_tdata[147:116])),
        .out_valid    (cv_valid[0]),
        .out_ready    (cv_ready[0]),
        .out_data     (cv_data[0])
    );

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        hed_cordic_stage #(
            .STAGE (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cv_valid[i]),
            .in_ready  (cv_ready[i]),
            .in_data   (cv_data[i]),
            .out_valid (cv_valid[i+1]),
            .out_ready (cv_ready[i+1]),
            .out_data  (cv_data[i+1])
        );
    end

    hed_post u_post (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cv_valid[CORDIC_STAGES]),
        .in_ready   (cv_ready[CORDIC_STAGES]),
        .in_data    (cv_data[CORDIC_STAGES]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .turn_angle (turn_angle),
        .distance   (distance),
        .no_move    (no_move)
    );

    assign m_axis_tdata = {4'b0, distance, turn_angle};
    assign m_axis_tuser = no_move;

    // Input can only be refused when every stage is full and the output is stalled.
    a_full_stall : assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input refused without output backpressure");

    a_no_move_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("no_move result carries nonzero payload");

    a_turn_range : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((turn_angle <= $signed(19'sd205888))
                           && (turn_angle >= $signed(-19'sd205888))))
        else $error("turn angle outside +-pi limit");

endmodule
`default_nettype wire
